### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### design/fct_pkg.sv
package fct_pkg;

  localparam int COORD_W    = 16;
  localparam int RAD_W      = 15;
  localparam int OP_W       = 2;
  localparam int VERDICT_W  = 2;
  localparam int PLANE_W    = 64;
  localparam int PLANE_REGS = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int Q_SHIFT    = 14;
  localparam int PROD_W     = 32;
  localparam int DIST_W     = 36;

  localparam logic [OP_W-1:0] OP_BOX    = 2'd0;
  localparam logic [OP_W-1:0] OP_SPHERE = 2'd1;
  localparam logic [OP_W-1:0] OP_POINT  = 2'd2;

  localparam logic [VERDICT_W-1:0] V_INSIDE    = 2'd0;
  localparam logic [VERDICT_W-1:0] V_INTERSECT = 2'd1;
  localparam logic [VERDICT_W-1:0] V_OUTSIDE   = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [PLANE_W-1:0] plane_t;

  typedef struct packed {
    logic outside;
    logic inter;
  } plane_flags_t;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } stage_en_t;

endpackage

### design/fct_plane_regs.sv
module fct_plane_regs import fct_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  plane_t               wr_data,
  output plane_t               planes [PLANE_REGS]
);

  plane_t planes_q [PLANE_REGS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PLANE_REGS; i++) begin
        planes_q[i] <= '0;
      end
    end else if (wr_en && (wr_index < CFG_IDX_W'(PLANE_REGS))) begin
      planes_q[wr_index] <= wr_data;
    end
  end

  assign planes = planes_q;

endmodule

### design/fct_plane_eval.sv
module fct_plane_eval import fct_pkg::*; (
  input  logic             clk,
  input  stage_en_t        en,
  input  plane_t           plane,
  input  logic [OP_W-1:0]  op,
  input  coord_t           lo_x,
  input  coord_t           lo_y,
  input  coord_t           lo_z,
  input  coord_t           hi_x,
  input  coord_t           hi_y,
  input  coord_t           hi_z,
  input  logic [OP_W-1:0]  op_s2,
  input  logic [RAD_W-1:0] radius_s2,
  output plane_flags_t     flags
);

  coord_t nx, ny, nz, off;
  coord_t pos_x, pos_y, pos_z, neg_x, neg_y, neg_z;
  logic   is_box;

  logic signed [PROD_W-1:0] ppx, ppy, ppz, pnx, pny, pnz;
  logic signed [DIST_W-1:0] off_scaled;
  logic signed [DIST_W-1:0] dpos, dneg;
  logic signed [DIST_W-1:0] r_scaled, r_upper;
  logic [RAD_W:0]           r_plus1;
  logic signed [DIST_W-1:0] sph_lo_chk;
  plane_flags_t             flags_next;

  assign nx  = plane[COORD_W-1:0];
  assign ny  = plane[2*COORD_W-1:COORD_W];
  assign nz  = plane[3*COORD_W-1:2*COORD_W];
  assign off = plane[4*COORD_W-1:3*COORD_W];

  // positive vertex: hi where the normal component is non-negative for a box, else lo
  assign is_box = (op == OP_BOX);
  assign pos_x  = (is_box && !nx[COORD_W-1]) ? hi_x : lo_x;
  assign pos_y  = (is_box && !ny[COORD_W-1]) ? hi_y : lo_y;
  assign pos_z  = (is_box && !nz[COORD_W-1]) ? hi_z : lo_z;
  assign neg_x  = nx[COORD_W-1] ? hi_x : lo_x;
  assign neg_y  = ny[COORD_W-1] ? hi_y : lo_y;
  assign neg_z  = nz[COORD_W-1] ? hi_z : lo_z;

  always_ff @(posedge clk) begin
    if (en.en1) begin
      ppx <= PROD_W'(nx * pos_x);
      ppy <= PROD_W'(ny * pos_y);
      ppz <= PROD_W'(nz * pos_z);
      pnx <= PROD_W'(nx * neg_x);
      pny <= PROD_W'(ny * neg_y);
      pnz <= PROD_W'(nz * neg_z);
    end
  end

  assign off_scaled = {{(DIST_W-COORD_W-Q_SHIFT){off[COORD_W-1]}}, off, {Q_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (en.en2) begin
      dpos <= off_scaled + DIST_W'(ppx) + DIST_W'(ppy) + DIST_W'(ppz);
      dneg <= off_scaled + DIST_W'(pnx) + DIST_W'(pny) + DIST_W'(pnz);
    end
  end

  assign r_plus1    = {1'b0, radius_s2} + (RAD_W+1)'(1);
  assign r_scaled   = {{(DIST_W-RAD_W-Q_SHIFT){1'b0}}, radius_s2, {Q_SHIFT{1'b0}}};
  assign r_upper    = {{(DIST_W-RAD_W-1-Q_SHIFT){1'b0}}, r_plus1, {Q_SHIFT{1'b0}}};
  assign sph_lo_chk = dpos + r_scaled;

  always_comb begin
    flags_next = '0;
    case (op_s2)
      OP_BOX: begin
        flags_next.outside = dpos[DIST_W-1];
        flags_next.inter   = dneg[DIST_W-1];
      end
      OP_SPHERE: begin
        flags_next.outside = sph_lo_chk[DIST_W-1];
        flags_next.inter   = (dpos < r_upper);
      end
      OP_POINT: begin
        flags_next.outside = dpos[DIST_W-1];
      end
      default: flags_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.en3) begin
      flags <= flags_next;
    end
  end

endmodule

### design/frustum_cull_test_unit.sv
// Frustum cull test: classifies an axis-aligned box, sphere or point against up to six
// programmed planes and returns inside, intersecting or outside. Fully pipelined: one item
// may be accepted every cycle unless back-pressure has filled the pipeline; its verdict is
// registered through the product stage, distance sum, plane compare and verdict register.
// Back-pressure propagates stage by stage, so bubbles are squeezed out. Planes are written
// through the cfg port (index 0..5, higher indexes ignored) and must only be changed while
// no item is in flight.
`include "assert_macros.svh"

module frustum_cull_test_unit import fct_pkg::*; #(
  parameter int NUM_PLANES = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PLANE_W-1:0]    cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [OP_W-1:0]       operation,
  input  coord_t                lo_x,
  input  coord_t                lo_y,
  input  coord_t                lo_z,
  input  coord_t                hi_x,
  input  coord_t                hi_y,
  input  coord_t                hi_z,
  input  logic [RAD_W-1:0]      radius,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [VERDICT_W-1:0]  verdict
);

  localparam int EVAL_PLANES = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;

  plane_t                planes [PLANE_REGS];
  plane_flags_t          flags [EVAL_PLANES];
  stage_en_t             en;
  logic                  en4;
  logic                  v1, v2, v3, v4;
  logic [OP_W-1:0]       op_s1, op_s2;
  logic [RAD_W-1:0]      radius_s1, radius_s2;
  logic                  any_out, any_inter;
  logic [VERDICT_W-1:0]  verdict_next;

  assign cfg_ready = 1'b1;

  fct_plane_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .planes   (planes)
  );

  assign en4    = !v4 || out_ready;
  assign en.en3 = !v3 || en4;
  assign en.en2 = !v2 || en.en3;
  assign en.en1 = !v1 || en.en2;
  assign in_ready = en.en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en.en1) v1 <= in_valid;
      if (en.en2) v2 <= v1;
      if (en.en3) v3 <= v2;
      if (en4)    v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      op_s1     <= operation;
      radius_s1 <= radius;
    end
    if (en.en2) begin
      op_s2     <= op_s1;
      radius_s2 <= radius_s1;
    end
  end

  for (genvar g = 0; g < EVAL_PLANES; g++) begin : g_plane
    fct_plane_eval u_eval (
      .clk       (clk),
      .en        (en),
      .plane     (planes[g]),
      .op        (operation),
      .lo_x      (lo_x),
      .lo_y      (lo_y),
      .lo_z      (lo_z),
      .hi_x      (hi_x),
      .hi_y      (hi_y),
      .hi_z      (hi_z),
      .op_s2     (op_s2),
      .radius_s2 (radius_s2),
      .flags     (flags[g])
    );
  end

  always_comb begin
    any_out   = 1'b0;
    any_inter = 1'b0;
    for (int i = 0; i < EVAL_PLANES; i++) begin
      any_out   = any_out | flags[i].outside;
      any_inter = any_inter | flags[i].inter;
    end
    if (any_out) begin
      verdict_next = V_OUTSIDE;
    end else if (any_inter) begin
      verdict_next = V_INTERSECT;
    end else begin
      verdict_next = V_INSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      verdict <= verdict_next;
    end
  end

  assign out_valid = v4;

  `ASSERT_IMPLIES(a_verdict_legal, clk, rst, out_valid, verdict != 2'd3)
  `ASSERT_IMPLIES(a_ready_flow, clk, rst, out_ready, in_ready)
  `ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && in_ready, v1)

endmodule
